// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the segment tree RTL.
// Both macros expect a clock named clk and an active-low reset named rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define XSTQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define XSTQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/xstq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XOR segment tree package
// Field widths, transaction types, command codes and controller states.
// ----------------------------------------------------------------------------
package xstq_pkg;

    localparam int ENTRIES_DEFAULT    = 1024;
    localparam int VALUE_BITS_DEFAULT = 32;

    localparam int START_W = 10;
    localparam int END_W   = 11;
    localparam int VALUE_W = 32;

    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [START_W-1:0] start_index;
        logic [END_W-1:0]   end_index;
        logic [VALUE_W-1:0] update_value;
    } cmd_t;

    typedef struct packed {
        logic [VALUE_W-1:0] range_xor;
        logic               range_error;
    } result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD,
        ST_Q_L,
        ST_Q_R,
        ST_Q_DONE
    } state_t;

endpackage

// ===== sv/xstq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module xstq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/xor_segment_tree_range_query.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XOR segment tree with point update and range query
// Holds ENTRIES values in a tree of 2*ENTRIES nodes kept in one RAM.
// ----------------------------------------------------------------------------
// Usage: a command transaction is taken at a rising edge where start is high
// and busy is low. With mode set to update, update_value is XORed into entry
// start_index and no result is produced; an update whose index is at or past
// ENTRIES is dropped. With mode set to query, one result transaction follows:
// the XOR of entries start_index up to but not including end_index, with
// range_error set (and range_xor zero) when the range is reversed or runs
// past ENTRIES. The result sits on the result port for one cycle with done
// high; the receiver must take it then, as there is no back-pressure.
// Timing: every tree node costs one RAM access with a registered read.
// An update walks the leaf-to-root path with an overlapped
// read-modify-write. A query walks up the tree level by level, taking
// the left boundary node in ST_Q_L and the right one in ST_Q_R; a bad
// range is answered straight from idle with no walk. Reset starts a
// clearing pass that writes zero to all 2*ENTRIES nodes, one per cycle,
// holding busy high until it is done.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xor_segment_tree_range_query #(
    parameter int ENTRIES    = xstq_pkg::ENTRIES_DEFAULT,
    parameter int VALUE_BITS = xstq_pkg::VALUE_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  xstq_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              done,
    output xstq_pkg::result_t result
);

    // Node numbering follows the usual bottom-up layout: leaves sit at
    // ENTRIES..2*ENTRIES-1, node k has children 2k and 2k+1, node 1 is root.
    localparam int NODE_COUNT = 2 * ENTRIES;
    localparam int NODE_AW    = $clog2(NODE_COUNT);
    // Walk pointers must also hold 2*ENTRIES, the exclusive end of a range.
    localparam int CNT_W      = $clog2(NODE_COUNT + 1);
    // Range checks are done in a width that holds both the fields and ENTRIES.
    localparam int CMP_W      = (CNT_W > xstq_pkg::END_W) ? CNT_W + 1 : xstq_pkg::END_W + 1;

    xstq_pkg::state_t  state_reg, state_next;
    logic [NODE_AW-1:0]    clr_reg, clr_next;
    logic [CNT_W-1:0]      l_reg, l_next;
    logic [CNT_W-1:0]      r_reg, r_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic                  acc_en_reg, acc_en_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic                  done_reg, done_next;
    xstq_pkg::result_t     result_reg, result_next;

    logic                  ram_wr_en;
    logic [NODE_AW-1:0]    ram_wr_addr;
    logic [VALUE_BITS-1:0] ram_wr_data;
    logic                  ram_rd_en;
    logic [NODE_AW-1:0]    ram_rd_addr;
    logic [VALUE_BITS-1:0] ram_rd_data;

    logic [CMP_W-1:0] s_ext;
    logic [CMP_W-1:0] e_ext;
    logic [CMP_W-1:0] ent_ext;
    logic [CNT_W-1:0] leaf_s;
    logic [CNT_W-1:0] leaf_e;
    logic             range_bad;
    logic [CNT_W-1:0] l_half;
    logic [CNT_W-1:0] r_dec;

    xstq_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (NODE_COUNT)
    ) u_tree_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Leaf positions of the command's indices. They only feed the walk when
    // the range checks pass, and then they fit in CNT_W bits.
    assign s_ext     = CMP_W'(cmd.start_index);
    assign e_ext     = CMP_W'(cmd.end_index);
    assign ent_ext   = CMP_W'(ENTRIES);
    assign leaf_s    = CNT_W'(s_ext + ent_ext);
    assign leaf_e    = CNT_W'(e_ext + ent_ext);
    assign range_bad = (s_ext > e_ext) || (e_ext > ent_ext);
    assign l_half    = l_reg >> 1;
    assign r_dec     = r_reg - CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= xstq_pkg::ST_CLEAR;
            clr_reg    <= '0;
            acc_en_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            acc_en_reg <= acc_en_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg      <= l_next;
        r_reg      <= r_next;
        acc_reg    <= acc_next;
        val_reg    <= val_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        l_next      = l_reg;
        r_next      = r_reg;
        val_next    = val_reg;
        acc_en_next = 1'b0;
        done_next   = 1'b0;
        result_next = result_reg;
        // A read issued by the query walk last cycle is folded in now.
        acc_next    = acc_en_reg ? (acc_reg ^ ram_rd_data) : acc_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = '0;
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = '0;

        case (state_reg)
            xstq_pkg::ST_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_reg;
                if (clr_reg == NODE_AW'(NODE_COUNT - 1))
                begin
                    state_next = xstq_pkg::ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + NODE_AW'(1);
                end
            end

            xstq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (cmd.mode == xstq_pkg::MODE_UPDATE)
                    begin
                        if (s_ext < ent_ext)
                        begin
                            // Fetch the leaf now so its data is there in ST_UPD.
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = leaf_s[NODE_AW-1:0];
                            l_next      = leaf_s;
                            val_next    = VALUE_BITS'(cmd.update_value);
                            state_next  = xstq_pkg::ST_UPD;
                        end
                    end
                    else if (range_bad)
                    begin
                        done_next               = 1'b1;
                        result_next.range_xor   = '0;
                        result_next.range_error = 1'b1;
                    end
                    else
                    begin
                        l_next     = leaf_s;
                        r_next     = leaf_e;
                        acc_next   = '0;
                        state_next = xstq_pkg::ST_Q_L;
                    end
                end
            end

            xstq_pkg::ST_UPD:
            begin
                // Every ancestor of the leaf changes by the same XOR value,
                // so each node on the path is read, XORed and written back.
                // The parent's read overlaps the child's write.
                ram_wr_en   = 1'b1;
                ram_wr_addr = l_reg[NODE_AW-1:0];
                ram_wr_data = ram_rd_data ^ val_reg;
                if (l_reg == CNT_W'(1))
                begin
                    state_next = xstq_pkg::ST_IDLE;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = l_half[NODE_AW-1:0];
                    l_next      = l_half;
                end
            end

            xstq_pkg::ST_Q_L:
            begin
                // Left boundary: an odd node is a right child, so take it
                // and step past it.
                if (l_reg < r_reg)
                begin
                    if (l_reg[0])
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = l_reg[NODE_AW-1:0];
                        acc_en_next = 1'b1;
                        l_next      = l_reg + CNT_W'(1);
                    end
                    state_next = xstq_pkg::ST_Q_R;
                end
                else
                begin
                    state_next = xstq_pkg::ST_Q_DONE;
                end
            end

            xstq_pkg::ST_Q_R:
            begin
                // Right boundary is exclusive: an odd end means node r-1 is
                // a left child inside the range. Then both move up a level;
                // r>>1 equals (r-1)>>1 for odd r.
                if (r_reg[0])
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = r_dec[NODE_AW-1:0];
                    acc_en_next = 1'b1;
                end
                l_next     = l_half;
                r_next     = r_reg >> 1;
                state_next = xstq_pkg::ST_Q_L;
            end

            xstq_pkg::ST_Q_DONE:
            begin
                done_next               = 1'b1;
                result_next.range_xor   = xstq_pkg::VALUE_W'(acc_reg);
                result_next.range_error = 1'b0;
                state_next              = xstq_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = xstq_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != xstq_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // The query walk keeps its left pointer at or below the right one.
    `XSTQ_ASSERT_IMP(a_walk_order, state_reg == xstq_pkg::ST_Q_L, l_reg <= r_reg, "query pointers crossed")
    // A query only reads the tree.
    `XSTQ_ASSERT_IMP(a_query_no_write, (state_reg == xstq_pkg::ST_Q_L) || (state_reg == xstq_pkg::ST_Q_R) || (state_reg == xstq_pkg::ST_Q_DONE), !ram_wr_en, "tree written during a query")
    // The overlapped update never reads the node it is writing.
    `XSTQ_ASSERT_IMP(a_rmw_no_overlap, ram_wr_en && ram_rd_en, ram_wr_addr != ram_rd_addr, "read and write hit the same node")
    // A finished walk always delivers its result on the next cycle.
    `XSTQ_ASSERT_NEXT(a_query_result, state_reg == xstq_pkg::ST_Q_DONE, done_reg && !busy, "query result not delivered")

endmodule
